// ----- hdl/aeb_pkg.sv -----
// package for the action edge buffer: default sizes, operation codes and
// the command struct passed from the top level to the counter bank
// no dependencies
package aeb_pkg;

  localparam int NUM_ACTIONS_DEF = 16;
  localparam int NEVER_VALUE_DEF = 255;

  localparam int MODE_W   = 2;
  localparam int HELD_W   = 16;
  localparam int INDEX_W  = 4;
  localparam int WINDOW_W = 8;

  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONSUME = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP     = 2'd3;

  typedef struct packed {
    logic advance;
    logic consume;
    logic flush;
  } cnt_cmd_t;

endpackage

// ----- hdl/action_edge_buffer_unit.sv -----
// top level of the action edge buffer: input register, held/pressed/released
// masks, result register; depends on aeb_pkg and aeb_counters
//
// usage:
//   a word is taken at a rising edge with start high and busy low; busy is
//   always low, so a word may be issued every cycle
//   the word lands in an input register; at the next edge the masks and the
//   counter bank update and the result is registered
//   done rises at the edge after the accepting edge and is high for exactly
//   one cycle, with pressed_mask, released_mask and consumed valid in it
//   one word per cycle sustained, one result per word, in order
//   the next word sees the state left by the previous one, since each state
//   update is a single registered step
//   reset clears the masks and the started flag and sets every counter to
//   the never value in the same cycle; no clearing pass
//   the receiver cannot stall; consumed is not held beyond its done cycle
module action_edge_buffer_unit #(
  parameter int NUM_ACTIONS = aeb_pkg::NUM_ACTIONS_DEF,
  parameter int NEVER_VALUE = aeb_pkg::NEVER_VALUE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [aeb_pkg::MODE_W-1:0]   mode,
  input  logic [aeb_pkg::HELD_W-1:0]   held_mask,
  input  logic [aeb_pkg::INDEX_W-1:0]  action_index,
  input  logic [aeb_pkg::WINDOW_W-1:0] window_limit,
  output logic                         done,
  output logic [aeb_pkg::HELD_W-1:0]   pressed_mask,
  output logic [aeb_pkg::HELD_W-1:0]   released_mask,
  output logic                         consumed
);

  logic                         in_valid;
  logic [aeb_pkg::MODE_W-1:0]   in_mode;
  logic [aeb_pkg::HELD_W-1:0]   in_held;
  logic [aeb_pkg::INDEX_W-1:0]  in_index;
  logic [aeb_pkg::WINDOW_W-1:0] in_window;

  logic [NUM_ACTIONS-1:0] held;
  logic [NUM_ACTIONS-1:0] pressed;
  logic [NUM_ACTIONS-1:0] released;
  logic                   started;

  logic [NUM_ACTIONS-1:0] held_ext;
  logic [NUM_ACTIONS-1:0] pressed_next;
  logic [NUM_ACTIONS-1:0] released_next;
  aeb_pkg::cnt_cmd_t      cmd;
  logic                   ok;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_mode   <= mode;
      in_held   <= held_mask;
      in_index  <= action_index;
      in_window <= window_limit;
    end
  end

  always_comb begin
    cmd.advance = 1'b0;
    cmd.consume = 1'b0;
    cmd.flush   = 1'b0;
    if (in_valid) begin
      unique case (in_mode)
        aeb_pkg::MODE_ADVANCE: cmd.advance = 1'b1;
        aeb_pkg::MODE_CONSUME: cmd.consume = 1'b1;
        aeb_pkg::MODE_FLUSH:   cmd.flush   = 1'b1;
        aeb_pkg::MODE_NOP:     ;
        default:               ;
      endcase
    end
  end

  // held bits beyond the port width read as zero
  always_comb begin
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if (i < aeb_pkg::HELD_W) begin
        held_ext[i] = in_held[i % aeb_pkg::HELD_W];
      end else begin
        held_ext[i] = 1'b0;
      end
    end
  end

  always_comb begin
    pressed_next  = pressed;
    released_next = released;
    if (cmd.advance) begin
      if (started) begin
        pressed_next  = held_ext & ~held;
        released_next = held & ~held_ext;
      end else begin
        pressed_next  = held_ext;
        released_next = '0;
      end
    end else if (cmd.flush) begin
      pressed_next  = '0;
      released_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      pressed  <= '0;
      released <= '0;
      started  <= 1'b0;
      done     <= 1'b0;
      consumed <= 1'b0;
    end else begin
      pressed  <= pressed_next;
      released <= released_next;
      done     <= in_valid;
      consumed <= ok;
      if (cmd.advance) begin
        held    <= held_ext;
        started <= 1'b1;
      end
    end
  end

  aeb_counters #(
    .NUM_ACTIONS (NUM_ACTIONS),
    .NEVER_VALUE (NEVER_VALUE)
  ) u_counters (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .press        (pressed_next),
    .action_index (in_index),
    .window_limit (in_window),
    .ok           (ok)
  );

  // masks hold until the next word updates them, so they serve as result data
  always_comb begin
    for (int j = 0; j < aeb_pkg::HELD_W; j++) begin
      if (j < NUM_ACTIONS) begin
        pressed_mask[j]  = pressed[j % NUM_ACTIONS];
        released_mask[j] = released[j % NUM_ACTIONS];
      end else begin
        pressed_mask[j]  = 1'b0;
        released_mask[j] = 1'b0;
      end
    end
  end

endmodule

// ----- hdl/aeb_counters.sv -----
// bank of per-action steps-since-press counters with the consume check
// depends on aeb_pkg
module aeb_counters #(
  parameter int NUM_ACTIONS = aeb_pkg::NUM_ACTIONS_DEF,
  parameter int NEVER_VALUE = aeb_pkg::NEVER_VALUE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  aeb_pkg::cnt_cmd_t            cmd,
  input  logic [NUM_ACTIONS-1:0]       press,
  input  logic [aeb_pkg::INDEX_W-1:0]  action_index,
  input  logic [aeb_pkg::WINDOW_W-1:0] window_limit,
  output logic                         ok
);

  localparam int CW   = $clog2(NEVER_VALUE + 1);
  localparam int CMPW = (CW > aeb_pkg::WINDOW_W) ? CW : aeb_pkg::WINDOW_W;
  localparam logic [CW-1:0] NEVER = CW'(NEVER_VALUE);

  logic [CW-1:0]          since_press      [NUM_ACTIONS];
  logic [CW-1:0]          since_press_next [NUM_ACTIONS];
  logic [NUM_ACTIONS-1:0] hit;
  logic [NUM_ACTIONS-1:0] usable;
  logic [CMPW-1:0]        window_ext;

  assign window_ext = CMPW'(window_limit);

  always_comb begin
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      hit[i]    = (32'(action_index) == i);
      usable[i] = (since_press[i] != NEVER) && (CMPW'(since_press[i]) <= window_ext);
    end
  end

  assign ok = cmd.consume && |(hit & usable);

  always_comb begin
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      since_press_next[i] = since_press[i];
      if (cmd.flush) begin
        since_press_next[i] = NEVER;
      end else if (cmd.advance) begin
        if (press[i]) begin
          since_press_next[i] = '0;
        end else if (since_press[i] != NEVER) begin
          since_press_next[i] = since_press[i] + CW'(1);
        end
      end else if (cmd.consume && hit[i] && usable[i]) begin
        since_press_next[i] = NEVER;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if (rst) begin
        since_press[i] <= NEVER;
      end else begin
        since_press[i] <= since_press_next[i];
      end
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// testbench for action_edge_buffer_unit: drives mode words in bursts and
// checks every result against a cycle-free model of the press/release masks
// and the per-action since-press counters; depends on aeb_pkg and the rtl
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0] pressed;
  logic [15:0] released;
  logic        consumed;
} edge_result_t;

class action_state_model;
  localparam int          ACTIONS = aeb_pkg::NUM_ACTIONS_DEF;
  localparam logic [7:0]  SPENT   = 8'(aeb_pkg::NEVER_VALUE_DEF);

  logic [15:0]  held_now;
  logic [15:0]  pressed_now;
  logic [15:0]  released_now;
  bit           started;
  logic [7:0]   since_press [ACTIONS];
  edge_result_t expected_results [$];
  int unsigned  mismatch_count;
  int unsigned  words_taken;
  int unsigned  results_seen;
  int unsigned  consumes_won;
  int unsigned  flushes;

  function new();
    held_now     = '0;
    pressed_now  = '0;
    released_now = '0;
    started      = 0;
    foreach (since_press[i]) since_press[i] = SPENT;
    mismatch_count = 0;
    words_taken    = 0;
    results_seen   = 0;
    consumes_won   = 0;
    flushes        = 0;
  endfunction

  function void take_word(logic [1:0] op, logic [15:0] held, logic [3:0] idx,
                          logic [7:0] win);
    logic [15:0]  prev;
    logic         won;
    edge_result_t want;
    won = 1'b0;
    words_taken++;
    case (op)
      aeb_pkg::MODE_ADVANCE: begin
        prev     = held_now;
        held_now = held;
        if (started) begin
          pressed_now  = held & ~prev;
          released_now = prev & ~held;
        end else begin
          pressed_now  = held;
          released_now = '0;
        end
        started = 1;
        for (int i = 0; i < ACTIONS; i++) begin
          if (pressed_now[i]) since_press[i] = '0;
          else if (since_press[i] < SPENT) since_press[i] = since_press[i] + 8'd1;
        end
      end
      aeb_pkg::MODE_CONSUME: begin
        if (idx < ACTIONS && since_press[idx] < SPENT && since_press[idx] <= win) begin
          since_press[idx] = SPENT;
          won = 1'b1;
          consumes_won++;
        end
      end
      aeb_pkg::MODE_FLUSH: begin
        foreach (since_press[i]) since_press[i] = SPENT;
        pressed_now  = '0;
        released_now = '0;
        flushes++;
      end
      default: ;
    endcase
    want.pressed  = pressed_now;
    want.released = released_now;
    want.consumed = won;
    expected_results.push_back(want);
  endfunction

  function void check_word(logic [15:0] got_pressed, logic [15:0] got_released,
                           logic got_consumed);
    edge_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result pressed %h released %h consumed %b",
               $time, got_pressed, got_released, got_consumed);
      mismatch_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got_pressed !== want.pressed) begin
      $display("%0t: pressed_mask expected %h actual %h", $time, want.pressed, got_pressed);
      mismatch_count++;
    end
    if (got_released !== want.released) begin
      $display("%0t: released_mask expected %h actual %h", $time, want.released,
               got_released);
      mismatch_count++;
    end
    if (got_consumed !== want.consumed) begin
      $display("%0t: consumed expected %b actual %b", $time, want.consumed, got_consumed);
      mismatch_count++;
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [aeb_pkg::MODE_W-1:0]   mode;
  logic [aeb_pkg::HELD_W-1:0]   held_mask;
  logic [aeb_pkg::INDEX_W-1:0]  action_index;
  logic [aeb_pkg::WINDOW_W-1:0] window_limit;
  logic                         done;
  logic [aeb_pkg::HELD_W-1:0]   pressed_mask;
  logic [aeb_pkg::HELD_W-1:0]   released_mask;
  logic                         consumed;

  action_state_model tracker = new();
  logic [15:0]       held_track;
  logic [3:0]        last_flipped;

  action_edge_buffer_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .held_mask(held_mask),
    .action_index(action_index),
    .window_limit(window_limit),
    .done(done),
    .pressed_mask(pressed_mask),
    .released_mask(released_mask),
    .consumed(consumed)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.take_word(mode, held_mask, action_index, window_limit);
      if (done) tracker.check_word(pressed_mask, released_mask, consumed);
    end
  end

  task send_word(input logic [1:0] op, input logic [15:0] held, input logic [3:0] idx,
                 input logic [7:0] win);
    start        <= 1'b1;
    mode         <= op;
    held_mask    <= held;
    action_index <= idx;
    window_limit <= win;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task pause_words(input int cycles);
    start        <= 1'b0;
    mode         <= 2'($urandom_range(0, 3));
    held_mask    <= 16'($urandom);
    action_index <= 4'($urandom);
    window_limit <= 8'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task advance_to(input logic [15:0] held);
    held_track = held;
    send_word(aeb_pkg::MODE_ADVANCE, held, 4'($urandom), 8'($urandom));
  endtask

  task random_word();
    logic [1:0]  op;
    logic [15:0] held;
    logic [3:0]  idx;
    logic [7:0]  win;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) op = aeb_pkg::MODE_ADVANCE;
    else if (pick < 85) op = aeb_pkg::MODE_CONSUME;
    else if (pick < 92) op = aeb_pkg::MODE_FLUSH;
    else op = aeb_pkg::MODE_NOP;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      last_flipped = 4'($urandom_range(0, 15));
      held = held_track ^ (16'h1 << last_flipped);
      if (pick == 0) held = held ^ (16'h1 << $urandom_range(0, 15));
    end else if (pick < 8) held = 16'($urandom);
    else if (pick == 8) held = 16'h0000;
    else held = 16'hffff;
    if (op == aeb_pkg::MODE_ADVANCE) held_track = held;
    idx = ($urandom_range(0, 9) < 6) ? last_flipped : 4'($urandom);
    win = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 6)) : 8'($urandom);
    send_word(op, held, idx, win);
  endtask

  // two actions pressed together and held; one is consumed just before its counter saturates, the other is refused
  task saturate_counters();
    advance_to(held_track & ~16'h0060);
    advance_to(held_track | 16'h0060);
    repeat (254) send_word(aeb_pkg::MODE_ADVANCE, held_track, 4'($urandom), 8'($urandom));
    send_word(aeb_pkg::MODE_CONSUME, held_track, 4'd5, 8'd253);
    send_word(aeb_pkg::MODE_CONSUME, held_track, 4'd6, 8'd254);
    repeat (2) send_word(aeb_pkg::MODE_ADVANCE, held_track, 4'($urandom), 8'($urandom));
    send_word(aeb_pkg::MODE_CONSUME, held_track, 4'd5, 8'd255);
  endtask

  initial begin
    int burst_left;
    rst          = 1'b1;
    start        = 1'b0;
    mode         = aeb_pkg::MODE_NOP;
    held_mask    = '0;
    action_index = '0;
    window_limit = '0;
    held_track   = '0;
    last_flipped = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_word(aeb_pkg::MODE_NOP, 16'hffff, 4'hf, 8'hff);
    send_word(aeb_pkg::MODE_CONSUME, 16'h0000, 4'd0, 8'd255);
    advance_to(16'hffff);
    advance_to(16'hffff);
    send_word(aeb_pkg::MODE_CONSUME, 16'hffff, 4'd15, 8'd0);
    send_word(aeb_pkg::MODE_CONSUME, 16'hffff, 4'd15, 8'd1);
    send_word(aeb_pkg::MODE_CONSUME, 16'hffff, 4'd15, 8'd255);
    advance_to(16'h0000);
    advance_to(16'haaaa);
    send_word(aeb_pkg::MODE_CONSUME, 16'h0000, 4'd1, 8'd0);
    send_word(aeb_pkg::MODE_CONSUME, 16'h0000, 4'd0, 8'd255);
    advance_to(16'h5555);
    send_word(aeb_pkg::MODE_NOP, 16'h0000, 4'd2, 8'd0);
    send_word(aeb_pkg::MODE_FLUSH, 16'hffff, 4'd2, 8'd255);
    send_word(aeb_pkg::MODE_CONSUME, 16'h0000, 4'd2, 8'd255);
    advance_to(16'h5555);
    advance_to(16'h0000);
    advance_to(16'hffff);
    send_word(aeb_pkg::MODE_CONSUME, 16'h0000, 4'd7, 8'd0);
    send_word(aeb_pkg::MODE_FLUSH, 16'h0000, 4'd0, 8'd0);
    advance_to(16'h8001);

    burst_left = $urandom_range(1, 20);
    for (int n = 0; n < 120; n++) begin
      if (n == 40) drain_results();
      if (n == 80) saturate_counters();
      random_word();
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause_words($urandom_range(1, 6));
        burst_left = $urandom_range(1, 20);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("ran %0d words through advance, consume, flush and no-op, %0d results checked",
             tracker.words_taken, tracker.results_seen);
    $display("%0d consumes granted, %0d flushes, counters driven to saturation once",
             tracker.consumes_won, tracker.flushes);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("action_edge_buffer_unit regression: pass");
    end else begin
      $display("action_edge_buffer_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("action_edge_buffer_unit regression: fail");
    $finish;
  end
endmodule
